@@ design/dpsi_pkg.sv @@
// package for the dump packet stream indexer
// shared types, record and error codes, signature tables; no dependencies
package dpsi_pkg;

  localparam int PosBits   = 48;
  localparam int FrameBits = 32;

  typedef enum logic [1:0] {
    KIND_FRAME   = 2'd0,
    KIND_SUMMARY = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_SIGNATURE = 3'd1,
    ERR_TABLE     = 3'd2,
    ERR_SPECIAL   = 3'd3,
    ERR_VARLEN    = 3'd4,
    ERR_TRUNCATED = 3'd5,
    ERR_NO_VIDEO  = 3'd6,
    ERR_OVERSIZE  = 3'd7
  } err_t;

  typedef enum logic [3:0] {
    PH_CHAN   = 4'd0,
    PH_TAG    = 4'd1,
    PH_MAGIC  = 4'd2,
    PH_NCH    = 4'd3,
    PH_ENTRY  = 4'd4,
    PH_NAME   = 4'd5,
    PH_TS     = 4'd6,
    PH_MINOR  = 4'd7,
    PH_VARLEN = 4'd8,
    PH_DIMS   = 4'd9,
    PH_SKIP   = 4'd10
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } in_word_t;

  typedef struct packed {
    kind_t                record_kind;
    err_t                 error_code;
    logic [FrameBits-1:0] frame_index;
    logic [PosBits-1:0]   packet_offset;
    logic [63:0]          frame_timestamp;
    logic [15:0]          frame_width;
    logic [15:0]          frame_height;
    logic [15:0]          largest_width;
    logic [15:0]          largest_height;
  } rec_t;

  function automatic logic [7:0] sig_byte(input logic [3:0] i);
    logic [7:0] r;
    case (i)
      4'd0, 4'd1: r = 8'hff;
      4'd2: r = "J";  4'd3: r = "P";  4'd4: r = "C";  4'd5: r = "R";
      4'd6: r = "R";  4'd7: r = "M";  4'd8: r = "U";  4'd9: r = "L";
      4'd10: r = "T"; 4'd11: r = "I"; 4'd12: r = "D"; 4'd13: r = "U";
      4'd14: r = "M";
      default: r = "P";
    endcase
    return r;
  endfunction

  function automatic logic [7:0] magic_byte(input logic [3:0] i);
    logic [7:0] r;
    case (i)
      4'd0: r = "R"; 4'd1: r = "M"; 4'd2: r = "U"; 4'd3: r = "L";
      4'd4: r = "T"; 4'd5: r = "I"; 4'd6: r = "D"; 4'd7: r = "U";
      4'd8: r = "M";
      default: r = "P";
    endcase
    return r;
  endfunction

endpackage

@@ design/dpsi_front.sv @@
// front end: input word queue holding data bytes and end markers
// depends on dpsi_pkg
module dpsi_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  dpsi_pkg::in_word_t wr_word,
  output logic              q_valid,
  input  logic              q_take,
  output dpsi_pkg::in_word_t q_word
);
  import dpsi_pkg::*;

  in_word_t    mem [4];
  logic [1:0]  wr_ptr, rd_ptr;
  logic [2:0]  count;
  logic        do_wr, do_rd;

  assign full    = (count == 3'd4);
  assign q_valid = (count != 3'd0);
  assign q_word  = mem[rd_ptr];
  assign do_wr   = push && !full;
  assign do_rd   = q_take && q_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + 2'd1;
      if (do_rd) rd_ptr <= rd_ptr + 2'd1;
      count <= count + {2'd0, do_wr} - {2'd0, do_rd};
    end
  end
endmodule

@@ design/dpsi_parser.sv @@
// back end: packet parser state machine producing frame, summary and error records
// depends on dpsi_pkg
module dpsi_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_take,
  input  dpsi_pkg::in_word_t in_word,
  output logic               rec_valid,
  input  logic               rec_ready,
  output dpsi_pkg::rec_t     rec
);
  import dpsi_pkg::*;

  phase_t              phase, phase_next;
  logic [3:0]          fcnt, fcnt_next;
  logic [15:0]         chan, chan_next;
  logic [31:0]         tag, tag_next;
  logic [63:0]         ts_off, ts_off_next;
  logic [63:0]         cur_ts, cur_ts_next;
  logic [15:0]         vid_chan, vid_chan_next;
  logic                vid_ok, vid_ok_next;
  logic [15:0]         ent_left, ent_left_next;
  logic [15:0]         ent_idx, ent_idx_next;
  logic [15:0]         ent_type, ent_type_next;
  logic [15:0]         name_left, name_left_next;
  logic [PosBits-1:0]  len_acc, len_acc_next;
  logic [PosBits-1:0]  pay_left, pay_left_next;
  logic [PosBits-1:0]  pos, pos_next;
  logic [PosBits-1:0]  pkt_start, pkt_start_next;
  logic [FrameBits-1:0] frames, frames_next;
  logic [15:0]         wtemp, wtemp_next;
  logic [15:0]         max_w, max_w_next;
  logic [15:0]         max_h, max_h_next;
  logic                halted, halted_next;
  logic                past_sig, past_sig_next;

  logic                emit;
  rec_t                rec_d;
  logic [7:0]          b;
  logic [15:0]         nleft;
  logic [15:0]         h;
  logic [PosBits-1:0]  acc_new;

  assign in_take = in_valid && (!rec_valid || rec_ready);
  assign b = in_word.data_byte;

  always_comb begin
    phase_next = phase; fcnt_next = fcnt; chan_next = chan; tag_next = tag;
    ts_off_next = ts_off; cur_ts_next = cur_ts; vid_chan_next = vid_chan;
    vid_ok_next = vid_ok; ent_left_next = ent_left; ent_idx_next = ent_idx;
    ent_type_next = ent_type; name_left_next = name_left; len_acc_next = len_acc;
    pay_left_next = pay_left; pos_next = pos; pkt_start_next = pkt_start;
    frames_next = frames; wtemp_next = wtemp; max_w_next = max_w;
    max_h_next = max_h; halted_next = halted; past_sig_next = past_sig;
    emit = 1'b0;
    nleft = '0;
    h = '0;
    acc_new = '0;
    rec_d = '{KIND_ERROR, ERR_NONE, frames, pos, cur_ts, 16'd0, 16'd0, max_w, max_h};

    if (in_word.end_of_file) begin
      if (!halted) begin
        emit = 1'b1;
        rec_d.record_kind = KIND_ERROR;
        if (!past_sig) rec_d.error_code = ERR_SIGNATURE;
        else if (phase == PH_TAG || phase == PH_DIMS || phase == PH_SKIP)
          rec_d.error_code = ERR_TRUNCATED;
        else if (phase == PH_MAGIC || phase == PH_NCH || phase == PH_ENTRY ||
                 phase == PH_NAME)
          rec_d.error_code = ERR_TABLE;
        else if (phase == PH_TS || phase == PH_MINOR || phase == PH_VARLEN)
          rec_d.error_code = ERR_VARLEN;
        else if (frames == '0) rec_d.error_code = ERR_NO_VIDEO;
        else rec_d.record_kind = KIND_SUMMARY;
      end
      phase_next = PH_CHAN; fcnt_next = '0; chan_next = '0; tag_next = '0;
      ts_off_next = '0; cur_ts_next = '0; vid_chan_next = '0; vid_ok_next = 1'b0;
      ent_left_next = '0; ent_idx_next = '0; ent_type_next = '0;
      name_left_next = '0; len_acc_next = '0; pay_left_next = '0; pos_next = '0;
      pkt_start_next = '0; frames_next = '0; wtemp_next = '0; max_w_next = '0;
      max_h_next = '0; halted_next = 1'b0; past_sig_next = 1'b0;
    end else if (!halted) begin
      pos_next = pos + 1'b1;
      rec_d.record_kind = KIND_ERROR;
      if (!past_sig && b != sig_byte(pos[3:0])) begin
        emit = 1'b1; rec_d.error_code = ERR_SIGNATURE;
      end else begin
        if (!past_sig && pos >= PosBits'(15)) past_sig_next = 1'b1;
        unique case (phase)
          PH_CHAN: begin
            chan_next = {chan[7:0], b};
            if (fcnt == 4'd1) begin
              fcnt_next = '0; tag_next = '0;
              phase_next = ({chan[7:0], b} == 16'hffff) ? PH_TAG : PH_TS;
            end else fcnt_next = fcnt + 4'd1;
          end
          PH_TAG: begin
            tag_next = {tag[23:0], b};
            if (fcnt == 4'd3) begin
              fcnt_next = '0;
              if ({tag[23:0], b} == 32'hffffffff) begin
                ts_off_next = ts_off + 64'hffffffff; phase_next = PH_CHAN;
              end else if ({tag[23:0], b} == 32'h4a504352) phase_next = PH_MAGIC;
              else begin emit = 1'b1; rec_d.error_code = ERR_SPECIAL; end
            end else fcnt_next = fcnt + 4'd1;
          end
          PH_MAGIC: begin
            if (b != magic_byte(fcnt)) begin
              emit = 1'b1; rec_d.error_code = ERR_TABLE;
            end else if (fcnt == 4'd9) begin
              fcnt_next = '0; ent_left_next = '0; phase_next = PH_NCH;
            end else fcnt_next = fcnt + 4'd1;
          end
          PH_NCH: begin
            ent_left_next = {ent_left[7:0], b};
            if (fcnt == 4'd1) begin
              fcnt_next = '0; ent_idx_next = '0; vid_ok_next = 1'b0;
              if ({ent_left[7:0], b} == 16'd0) begin
                emit = 1'b1; rec_d.error_code = ERR_TABLE;
              end else phase_next = PH_ENTRY;
            end else fcnt_next = fcnt + 4'd1;
          end
          PH_ENTRY: begin
            if (fcnt == 4'd2 || fcnt == 4'd3) ent_type_next = {ent_type[7:0], b};
            else if (fcnt >= 4'd4) name_left_next = {name_left[7:0], b};
            if (fcnt == 4'd5) begin
              fcnt_next = '0;
              if (ent_type == 16'd0) begin
                vid_chan_next = ent_idx; vid_ok_next = 1'b1;
              end
              if ({name_left[7:0], b} == 16'd0) begin
                ent_idx_next = ent_idx + 16'd1;
                ent_left_next = ent_left - 16'd1;
                if (ent_left == 16'd1) begin
                  if (!(vid_ok || ent_type == 16'd0)) begin
                    emit = 1'b1; rec_d.error_code = ERR_TABLE;
                  end else phase_next = PH_CHAN;
                end
              end else phase_next = PH_NAME;
            end else fcnt_next = fcnt + 4'd1;
          end
          PH_NAME: begin
            nleft = name_left - 16'd1;
            name_left_next = nleft;
            if (nleft == 16'd0) begin
              phase_next = PH_ENTRY;
              ent_idx_next = ent_idx + 16'd1;
              ent_left_next = ent_left - 16'd1;
              if (ent_left == 16'd1) begin
                if (!vid_ok) begin
                  emit = 1'b1; rec_d.error_code = ERR_TABLE;
                end else phase_next = PH_CHAN;
              end
            end
          end
          PH_TS: begin
            tag_next = {tag[23:0], b};
            if (fcnt == 4'd3) begin
              fcnt_next = '0;
              cur_ts_next = {32'd0, tag[23:0], b} + ts_off;
              pkt_start_next = pos + 1'b1;
              phase_next = PH_MINOR;
            end else fcnt_next = fcnt + 4'd1;
          end
          PH_MINOR: begin
            len_acc_next = '0; phase_next = PH_VARLEN;
          end
          PH_VARLEN: begin
            acc_new = {len_acc[PosBits-8:0], b[6:0]};
            if (len_acc[PosBits-1:PosBits-7] != '0) begin
              emit = 1'b1; rec_d.error_code = ERR_OVERSIZE;
            end else begin
              len_acc_next = acc_new;
              if (!b[7]) begin
                if (vid_ok && chan == vid_chan) begin
                  if (acc_new < PosBits'(4)) begin
                    emit = 1'b1; rec_d.error_code = ERR_TRUNCATED;
                  end else begin
                    pay_left_next = acc_new - PosBits'(4);
                    tag_next = '0; fcnt_next = '0; phase_next = PH_DIMS;
                  end
                end else if (acc_new == '0) phase_next = PH_CHAN;
                else begin
                  pay_left_next = acc_new; phase_next = PH_SKIP;
                end
              end
            end
          end
          PH_DIMS: begin
            tag_next = {tag[23:0], b};
            if (fcnt == 4'd1) wtemp_next = {tag[7:0], b};
            if (fcnt == 4'd3) begin
              h = {tag[7:0], b};
              fcnt_next = '0;
              if (wtemp > max_w) max_w_next = wtemp;
              if (h > max_h) max_h_next = h;
              emit = 1'b1;
              rec_d = '{KIND_FRAME, ERR_NONE, frames, pkt_start, cur_ts, wtemp, h,
                        (wtemp > max_w) ? wtemp : max_w, (h > max_h) ? h : max_h};
              frames_next = frames + 1'b1;
              phase_next = (pay_left != '0) ? PH_SKIP : PH_CHAN;
            end else fcnt_next = fcnt + 4'd1;
          end
          PH_SKIP: begin
            pay_left_next = pay_left - 1'b1;
            if (pay_left == PosBits'(1)) phase_next = PH_CHAN;
          end
          default: phase_next = PH_CHAN;
        endcase
        if (emit && rec_d.record_kind == KIND_ERROR) halted_next = 1'b1;
      end
      if (emit && rec_d.error_code == ERR_SIGNATURE) halted_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_CHAN; fcnt <= '0; chan <= '0; tag <= '0; ts_off <= '0;
      cur_ts <= '0; vid_chan <= '0; vid_ok <= 1'b0; ent_left <= '0;
      ent_idx <= '0; ent_type <= '0; name_left <= '0; len_acc <= '0;
      pay_left <= '0; pos <= '0; pkt_start <= '0; frames <= '0; wtemp <= '0;
      max_w <= '0; max_h <= '0; halted <= 1'b0; past_sig <= 1'b0;
      rec_valid <= 1'b0;
    end else begin
      if (in_take) begin
        phase <= phase_next; fcnt <= fcnt_next; chan <= chan_next; tag <= tag_next;
        ts_off <= ts_off_next; cur_ts <= cur_ts_next; vid_chan <= vid_chan_next;
        vid_ok <= vid_ok_next; ent_left <= ent_left_next; ent_idx <= ent_idx_next;
        ent_type <= ent_type_next; name_left <= name_left_next;
        len_acc <= len_acc_next; pay_left <= pay_left_next; pos <= pos_next;
        pkt_start <= pkt_start_next; frames <= frames_next; wtemp <= wtemp_next;
        max_w <= max_w_next; max_h <= max_h_next; halted <= halted_next;
        past_sig <= past_sig_next;
      end
      if (in_take) rec_valid <= emit;
      else if (rec_ready) rec_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && emit) rec <= rec_d;
  end
endmodule

@@ design/dpsi_out_queue.sv @@
// result queue: holds records until popped
// depends on dpsi_pkg
module dpsi_out_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  dpsi_pkg::rec_t wr_rec,
  output logic           empty,
  input  logic           pop,
  output dpsi_pkg::rec_t rd_rec
);
  import dpsi_pkg::*;

  rec_t       mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       do_wr, do_rd;

  assign wr_ready = (count != 2'd2);
  assign empty    = (count == 2'd0);
  assign rd_rec   = mem[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_ptr] <= wr_rec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= ~wr_ptr;
      if (do_rd) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, do_wr} - {1'b0, do_rd};
    end
  end
endmodule

@@ design/dump_packet_stream_indexer.sv @@
// top level of the dump packet stream indexer
// depends on dpsi_pkg, dpsi_front, dpsi_parser, dpsi_out_queue
// One byte of the dump file (or the end marker) is taken per clock cycle
// while the input queue is not full; the parser handles one byte per cycle
// while the result queue has room. A four-entry input queue feeds the parser
// and a two-entry result queue follows it; records reach the result ports
// through the input queue, the parser's record register and result queue.
module dump_packet_stream_indexer (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte,
  input  logic        end_of_file,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  record_kind,
  output logic [2:0]  error_code,
  output logic [31:0] frame_index,
  output logic [47:0] packet_offset,
  output logic [63:0] frame_timestamp,
  output logic [15:0] frame_width,
  output logic [15:0] frame_height,
  output logic [15:0] largest_width,
  output logic [15:0] largest_height
);
  import dpsi_pkg::*;

  in_word_t w_in, w_q;
  logic     q_valid, q_take;
  logic     r_valid, r_ready;
  rec_t     r_rec, o_rec;

  assign w_in = '{data_byte, end_of_file};

  dpsi_front u_front (
    .clk, .rst, .push, .full, .wr_word(w_in),
    .q_valid, .q_take, .q_word(w_q)
  );

  dpsi_parser u_parser (
    .clk, .rst, .in_valid(q_valid), .in_take(q_take), .in_word(w_q),
    .rec_valid(r_valid), .rec_ready(r_ready), .rec(r_rec)
  );

  dpsi_out_queue u_outq (
    .clk, .rst, .wr_valid(r_valid), .wr_ready(r_ready), .wr_rec(r_rec),
    .empty, .pop, .rd_rec(o_rec)
  );

  assign record_kind     = o_rec.record_kind;
  assign error_code      = o_rec.error_code;
  assign frame_index     = o_rec.frame_index;
  assign packet_offset   = o_rec.packet_offset;
  assign frame_timestamp = o_rec.frame_timestamp;
  assign frame_width     = o_rec.frame_width;
  assign frame_height    = o_rec.frame_height;
  assign largest_width   = o_rec.largest_width;
  assign largest_height  = o_rec.largest_height;
endmodule

@@ design/dpsi_checker.sv @@
// port checker for the dump packet stream indexer
// depends on dpsi_pkg and dump_packet_stream_indexer ports only
module dpsi_checker (
  input logic        clk,
  input logic        rst,
  input logic        empty,
  input logic        pop,
  input logic [1:0]  record_kind,
  input logic [2:0]  error_code,
  input logic [15:0] frame_width,
  input logic [15:0] frame_height,
  input logic [15:0] largest_width,
  input logic [15:0] largest_height
);
  import dpsi_pkg::*;

  a_kind: assert property (@(posedge clk) disable iff (rst)
    !empty |-> record_kind <= KIND_ERROR) else $error("bad record kind");
  a_code: assert property (@(posedge clk) disable iff (rst)
    !empty && record_kind != KIND_ERROR |-> error_code == ERR_NONE)
    else $error("code without error");
  a_max: assert property (@(posedge clk) disable iff (rst)
    !empty && record_kind == KIND_FRAME |-> largest_width >= frame_width &&
    largest_height >= frame_height) else $error("maximum below frame");
  a_dims: assert property (@(posedge clk) disable iff (rst)
    !empty && record_kind != KIND_FRAME |-> frame_width == 16'd0 && frame_height == 16'd0)
    else $error("dims in summary");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty) else $error("record dropped");
endmodule

bind dump_packet_stream_indexer dpsi_checker u_chk (
  .clk, .rst, .empty, .pop, .record_kind, .error_code,
  .frame_width, .frame_height, .largest_width, .largest_height
);
